@@ rtl/core/m3i_pkg.sv @@
// Shared constants, types and width helpers for the 3x3 matrix inverter.
package m3i_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_ELEM       = 9;
    localparam int ROW_LEN        = 3;
    // cofactor 2 + determinant 3 + prep 2 + output 1
    localparam int FRONT_STAGES   = 8;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_flags;

    function automatic int det_width(int e);
        return 3 * e + 1;
    endfunction

    // Remainder must hold the shifted numerator and the divisor shifted by e.
    function automatic int rem_width(int e, int f);
        int nw;
        int dw;
        nw = 2 * e - 1 + 2 * f;
        dw = 3 * e + 1 + e;
        return (nw > dw) ? nw : dw;
    endfunction

    function automatic int latency(int e);
        return e + FRONT_STAGES;
    endfunction

endpackage

@@ rtl/core/matrix3_inverse_determinant_top.sv @@
// Top level of the pipelined 3x3 matrix inverter.
//
// Usage:
//   Drive the nine signed Q16.16 elements on i_in_rXcY and raise start.
//   A word is taken at each rising edge with start high and busy low.
//   busy never rises: the pipeline takes a new matrix every cycle.
//   The result word (nine inverse entries, det_value, singular) appears
//   with o_valid high for one cycle; the receiver must take it then, it
//   cannot stall.
// Throughput: one matrix per cycle. The divider resolves one quotient bit
//   per stage in nine parallel lanes; it follows 2 cofactor, 3 determinant
//   and 2 prep stages, and one output register follows it.
// Singular input (determinant exactly zero): inverse and det_value are
//   zero and o_singular is high. Out-of-range results saturate.
// Reset (i_rst_n low, synchronous) clears all valid bits; words in flight
//   are dropped and no o_valid pulse follows until new words enter.
module matrix3_inverse_determinant_top #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ELEM_WIDTH-1:0] i_in_r1c1,
    input  logic [ELEM_WIDTH-1:0] i_in_r1c2,
    input  logic [ELEM_WIDTH-1:0] i_in_r1c3,
    input  logic [ELEM_WIDTH-1:0] i_in_r2c1,
    input  logic [ELEM_WIDTH-1:0] i_in_r2c2,
    input  logic [ELEM_WIDTH-1:0] i_in_r2c3,
    input  logic [ELEM_WIDTH-1:0] i_in_r3c1,
    input  logic [ELEM_WIDTH-1:0] i_in_r3c2,
    input  logic [ELEM_WIDTH-1:0] i_in_r3c3,
    output logic                  o_valid,
    output logic [ELEM_WIDTH-1:0] o_inv_r1c1,
    output logic [ELEM_WIDTH-1:0] o_inv_r1c2,
    output logic [ELEM_WIDTH-1:0] o_inv_r1c3,
    output logic [ELEM_WIDTH-1:0] o_inv_r2c1,
    output logic [ELEM_WIDTH-1:0] o_inv_r2c2,
    output logic [ELEM_WIDTH-1:0] o_inv_r2c3,
    output logic [ELEM_WIDTH-1:0] o_inv_r3c1,
    output logic [ELEM_WIDTH-1:0] o_inv_r3c2,
    output logic [ELEM_WIDTH-1:0] o_inv_r3c3,
    output logic [ELEM_WIDTH-1:0] o_det_value,
    output logic                  o_singular
);
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int DW = m3i_pkg::det_width(ELEM_WIDTH);
    localparam int RW = m3i_pkg::rem_width(ELEM_WIDTH, FRAC_BITS);

    logic signed [ELEM_WIDTH-1:0] elem [m3i_pkg::NUM_ELEM];
    logic                         accept;

    // no back-pressure anywhere: the word enters whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign elem[0] = $signed(i_in_r1c1);
    assign elem[1] = $signed(i_in_r1c2);
    assign elem[2] = $signed(i_in_r1c3);
    assign elem[3] = $signed(i_in_r2c1);
    assign elem[4] = $signed(i_in_r2c2);
    assign elem[5] = $signed(i_in_r2c3);
    assign elem[6] = $signed(i_in_r3c1);
    assign elem[7] = $signed(i_in_r3c2);
    assign elem[8] = $signed(i_in_r3c3);

    // cofactor stage outputs
    logic                         cof_valid;
    logic signed [PW-1:0]         cof_adj  [m3i_pkg::NUM_ELEM];
    logic signed [ELEM_WIDTH-1:0] cof_row1 [m3i_pkg::ROW_LEN];

    m3i_cofactor #(.ELEM_WIDTH(ELEM_WIDTH)) u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_elem  (elem),
        .o_valid (cof_valid),
        .o_adj   (cof_adj),
        .o_row1  (cof_row1)
    );

    // exact determinant, adjugate delayed alongside
    logic                 det_valid;
    logic signed [PW-1:0] det_adj [m3i_pkg::NUM_ELEM];
    logic signed [DW-1:0] det_full;

    m3i_det #(.ELEM_WIDTH(ELEM_WIDTH)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_valid),
        .i_adj   (cof_adj),
        .i_row1  (cof_row1),
        .o_valid (det_valid),
        .o_adj   (det_adj),
        .o_det   (det_full)
    );

    // divider operands in sign-magnitude form
    m3i_pkg::t_flags       prep_flags;
    logic [RW-1:0]         prep_num [m3i_pkg::NUM_ELEM];
    logic [DW-1:0]         prep_den;
    logic                  prep_neg [m3i_pkg::NUM_ELEM];
    logic                  prep_ovf [m3i_pkg::NUM_ELEM];
    logic [ELEM_WIDTH-1:0] prep_detv;

    m3i_prep #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (det_valid),
        .i_adj       (det_adj),
        .i_det       (det_full),
        .o_flags     (prep_flags),
        .o_num       (prep_num),
        .o_den       (prep_den),
        .o_neg       (prep_neg),
        .o_ovf       (prep_ovf),
        .o_det_value (prep_detv)
    );

    logic [ELEM_WIDTH-1:0] inv [m3i_pkg::NUM_ELEM];

    m3i_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flags     (prep_flags),
        .i_num       (prep_num),
        .i_den       (prep_den),
        .i_neg       (prep_neg),
        .i_ovf       (prep_ovf),
        .i_det_value (prep_detv),
        .o_valid     (o_valid),
        .o_inv       (inv),
        .o_det_value (o_det_value),
        .o_singular  (o_singular)
    );

    assign o_inv_r1c1 = inv[0];
    assign o_inv_r1c2 = inv[1];
    assign o_inv_r1c3 = inv[2];
    assign o_inv_r2c1 = inv[3];
    assign o_inv_r2c2 = inv[4];
    assign o_inv_r2c3 = inv[5];
    assign o_inv_r3c1 = inv[6];
    assign o_inv_r3c2 = inv[7];
    assign o_inv_r3c3 = inv[8];

endmodule

@@ rtl/core/m3i_cofactor.sv @@
// Cofactor products and adjugate entries, two register stages.
module m3i_cofactor #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem [m3i_pkg::NUM_ELEM],
    output logic                          o_valid,
    output logic signed [2*ELEM_WIDTH-1:0] o_adj [m3i_pkg::NUM_ELEM],
    output logic signed [ELEM_WIDTH-1:0]  o_row1 [m3i_pkg::ROW_LEN]
);
    localparam int PW = 2 * ELEM_WIDTH;

    logic                         r_v1;
    logic                         r_v2;
    logic signed [ELEM_WIDTH-1:0] r_row1_a [m3i_pkg::ROW_LEN];
    logic signed [ELEM_WIDTH-1:0] r_row1_b [m3i_pkg::ROW_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3i_pkg::ROW_LEN; k++) begin
            r_row1_a[k] <= i_elem[k];
            r_row1_b[k] <= r_row1_a[k];
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < m3i_pkg::ROW_LEN; r++) begin : g_row
            for (c = 0; c < m3i_pkg::ROW_LEN; c++) begin : g_col
                localparam int K  = r * 3 + c;
                localparam int IA = ((c + 1) % 3) * 3 + (r + 1) % 3;
                localparam int IB = ((c + 2) % 3) * 3 + (r + 2) % 3;
                localparam int IC = ((c + 1) % 3) * 3 + (r + 2) % 3;
                localparam int ID = ((c + 2) % 3) * 3 + (r + 1) % 3;
                logic signed [PW-1:0] r_p;
                logic signed [PW-1:0] r_q;
                logic signed [PW-1:0] r_adj;
                always_ff @(posedge i_clk) begin
                    r_p   <= i_elem[IA] * i_elem[IB];
                    r_q   <= i_elem[IC] * i_elem[ID];
                    // difference stays below 2^(PW-1) in magnitude
                    r_adj <= r_p - r_q;
                end
                assign o_adj[K] = r_adj;
            end
        end
    endgenerate

    assign o_valid = r_v2;
    assign o_row1  = r_row1_b;

endmodule

@@ rtl/core/m3i_det.sv @@
// Determinant from row one and the first adjugate column, three stages.
module m3i_det #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [2*ELEM_WIDTH-1:0] i_adj [m3i_pkg::NUM_ELEM],
    input  logic signed [ELEM_WIDTH-1:0]   i_row1 [m3i_pkg::ROW_LEN],
    output logic                           o_valid,
    output logic signed [2*ELEM_WIDTH-1:0] o_adj [m3i_pkg::NUM_ELEM],
    output logic signed [m3i_pkg::det_width(ELEM_WIDTH)-1:0] o_det
);
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int DW = m3i_pkg::det_width(ELEM_WIDTH);

    logic [2:0]           r_v;
    logic signed [PW:0]   r_plo  [m3i_pkg::ROW_LEN];
    logic signed [PW-1:0] r_phi  [m3i_pkg::ROW_LEN];
    logic signed [DW-1:0] r_term [m3i_pkg::ROW_LEN];
    logic signed [DW-1:0] r_det;
    logic signed [PW-1:0] r_adj_a [m3i_pkg::NUM_ELEM];
    logic signed [PW-1:0] r_adj_b [m3i_pkg::NUM_ELEM];
    logic signed [PW-1:0] r_adj_c [m3i_pkg::NUM_ELEM];
    logic signed [DW-1:0] n_term [m3i_pkg::ROW_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // adj split in a low unsigned half and a high signed half
    always_comb begin
        logic signed [DW-1:0] hi_ext;
        logic signed [DW-1:0] lo_ext;
        for (int k = 0; k < m3i_pkg::ROW_LEN; k++) begin
            hi_ext    = DW'(r_phi[k]);
            lo_ext    = DW'(r_plo[k]);
            n_term[k] = (hi_ext <<< ELEM_WIDTH) + lo_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3i_pkg::ROW_LEN; k++) begin
            r_plo[k]  <= i_row1[k] * $signed({1'b0, i_adj[k*3][ELEM_WIDTH-1:0]});
            r_phi[k]  <= i_row1[k] * $signed(i_adj[k*3][PW-1:ELEM_WIDTH]);
            r_term[k] <= n_term[k];
        end
        r_det <= r_term[0] + r_term[1] + r_term[2];
        for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
            r_adj_a[k] <= i_adj[k];
            r_adj_b[k] <= r_adj_a[k];
            r_adj_c[k] <= r_adj_b[k];
        end
    end

    assign o_valid = r_v[2];
    assign o_adj   = r_adj_c;
    assign o_det   = r_det;

endmodule

@@ rtl/core/m3i_prep.sv @@
// Magnitudes, determinant output and quotient overflow check, two stages.
module m3i_prep #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [2*ELEM_WIDTH-1:0] i_adj [m3i_pkg::NUM_ELEM],
    input  logic signed [m3i_pkg::det_width(ELEM_WIDTH)-1:0] i_det,
    output m3i_pkg::t_flags                o_flags,
    output logic [m3i_pkg::rem_width(ELEM_WIDTH, FRAC_BITS)-1:0] o_num [m3i_pkg::NUM_ELEM],
    output logic [m3i_pkg::det_width(ELEM_WIDTH)-1:0] o_den,
    output logic                           o_neg [m3i_pkg::NUM_ELEM],
    output logic                           o_ovf [m3i_pkg::NUM_ELEM],
    output logic [ELEM_WIDTH-1:0]          o_det_value
);
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int DW = m3i_pkg::det_width(ELEM_WIDTH);
    localparam int RW = m3i_pkg::rem_width(ELEM_WIDTH, FRAC_BITS);
    localparam logic [DW-1:0] HALF = DW'(1) << (ELEM_WIDTH - 1);
    localparam logic [ELEM_WIDTH-1:0] MAXV = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] MINV = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic                  r_va, r_vb;
    logic                  r_sing_a, r_sing_b;
    logic [RW-1:0]         r_num_a [m3i_pkg::NUM_ELEM];
    logic [RW-1:0]         r_num_b [m3i_pkg::NUM_ELEM];
    logic                  r_neg_a [m3i_pkg::NUM_ELEM];
    logic                  r_neg_b [m3i_pkg::NUM_ELEM];
    logic                  r_ovf   [m3i_pkg::NUM_ELEM];
    logic [DW-1:0]         r_den_a, r_den_b;
    logic [ELEM_WIDTH-1:0] r_detv_a, r_detv_b;

    logic [RW-1:0]         n_num [m3i_pkg::NUM_ELEM];
    logic [DW-1:0]         n_den;
    logic [ELEM_WIDTH-1:0] n_detv;

    always_comb begin
        logic [PW-1:0] amag;
        logic [DW-1:0] dq;
        for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
            amag     = i_adj[k][PW-1] ? PW'(-i_adj[k]) : PW'(i_adj[k]);
            n_num[k] = RW'(amag) << (2 * FRAC_BITS);
        end
        n_den = i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
        dq    = n_den >> (2 * FRAC_BITS);
        if (i_det[DW-1]) begin
            n_detv = (dq > HALF) ? MINV : ELEM_WIDTH'(-dq);
        end else begin
            n_detv = (dq >= HALF) ? MAXV : dq[ELEM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
            r_num_a[k] <= n_num[k];
            r_neg_a[k] <= i_adj[k][PW-1] ^ i_det[DW-1];
            r_num_b[k] <= r_num_a[k];
            r_neg_b[k] <= r_neg_a[k];
            // quotient would need more than ELEM_WIDTH bits
            r_ovf[k]   <= r_num_a[k] >= (RW'(r_den_a) << ELEM_WIDTH);
        end
        r_den_a  <= n_den;
        r_sing_a <= (i_det == '0);
        r_detv_a <= n_detv;
        r_den_b  <= r_den_a;
        r_sing_b <= r_sing_a;
        r_detv_b <= r_detv_a;
    end

    assign o_flags.valid    = r_vb;
    assign o_flags.singular = r_sing_b;
    assign o_num            = r_num_b;
    assign o_den            = r_den_b;
    assign o_neg            = r_neg_b;
    assign o_ovf            = r_ovf;
    assign o_det_value      = r_detv_b;

endmodule

@@ rtl/core/m3i_div.sv @@
// Nine-lane restoring divider, one quotient bit per stage, then saturation.
module m3i_div #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  m3i_pkg::t_flags                i_flags,
    input  logic [m3i_pkg::rem_width(ELEM_WIDTH, FRAC_BITS)-1:0] i_num [m3i_pkg::NUM_ELEM],
    input  logic [m3i_pkg::det_width(ELEM_WIDTH)-1:0] i_den,
    input  logic                           i_neg [m3i_pkg::NUM_ELEM],
    input  logic                           i_ovf [m3i_pkg::NUM_ELEM],
    input  logic [ELEM_WIDTH-1:0]          i_det_value,
    output logic                           o_valid,
    output logic [ELEM_WIDTH-1:0]          o_inv [m3i_pkg::NUM_ELEM],
    output logic [ELEM_WIDTH-1:0]          o_det_value,
    output logic                           o_singular
);
    localparam int E  = ELEM_WIDTH;
    localparam int DW = m3i_pkg::det_width(ELEM_WIDTH);
    localparam int RW = m3i_pkg::rem_width(ELEM_WIDTH, FRAC_BITS);
    localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
    localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

    // stage registers, index is the stage that wrote them
    logic [RW-1:0]   s_rem   [1:E][m3i_pkg::NUM_ELEM];
    logic [E-1:0]    s_q     [1:E][m3i_pkg::NUM_ELEM];
    logic            s_neg   [1:E][m3i_pkg::NUM_ELEM];
    logic            s_ovf   [1:E][m3i_pkg::NUM_ELEM];
    logic [DW-1:0]   s_den   [1:E];
    logic [E-1:0]    s_detv  [1:E];
    logic            s_valid [1:E];
    logic            s_sing  [1:E];

    genvar j, k;
    generate
        for (j = 0; j < E; j++) begin : g_stage
            localparam int B = E - 1 - j;
            logic [RW-1:0] a_rem [m3i_pkg::NUM_ELEM];
            logic [E-1:0]  a_q   [m3i_pkg::NUM_ELEM];
            logic          a_neg [m3i_pkg::NUM_ELEM];
            logic          a_ovf [m3i_pkg::NUM_ELEM];
            logic [DW-1:0] a_den;
            logic [E-1:0]  a_detv;
            logic          a_valid;
            logic          a_sing;
            logic [RW-1:0] dsh;

            if (j == 0) begin : g_first
                assign a_den   = i_den;
                assign a_detv  = i_det_value;
                assign a_valid = i_flags.valid;
                assign a_sing  = i_flags.singular;
                for (k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_lane
                    assign a_rem[k] = i_num[k];
                    assign a_q[k]   = '0;
                    assign a_neg[k] = i_neg[k];
                    assign a_ovf[k] = i_ovf[k];
                end
            end else begin : g_next
                assign a_den   = s_den[j];
                assign a_detv  = s_detv[j];
                assign a_valid = s_valid[j];
                assign a_sing  = s_sing[j];
                for (k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_lane
                    assign a_rem[k] = s_rem[j][k];
                    assign a_q[k]   = s_q[j][k];
                    assign a_neg[k] = s_neg[j][k];
                    assign a_ovf[k] = s_ovf[j][k];
                end
            end

            assign dsh = RW'(a_den) << B;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    s_valid[j+1] <= 1'b0;
                end else begin
                    s_valid[j+1] <= a_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                s_sing[j+1] <= a_sing;
                s_den[j+1]  <= a_den;
                s_detv[j+1] <= a_detv;
                for (int n = 0; n < m3i_pkg::NUM_ELEM; n++) begin
                    s_neg[j+1][n] <= a_neg[n];
                    s_ovf[j+1][n] <= a_ovf[n];
                    if (a_rem[n] >= dsh) begin
                        s_rem[j+1][n] <= a_rem[n] - dsh;
                        s_q[j+1][n]   <= a_q[n] | (E'(1) << B);
                    end else begin
                        s_rem[j+1][n] <= a_rem[n];
                        s_q[j+1][n]   <= a_q[n];
                    end
                end
            end
        end
    endgenerate

    logic           r_valid;
    logic           r_sing;
    logic [E-1:0]   r_detv;
    logic [E-1:0]   r_inv [m3i_pkg::NUM_ELEM];
    logic [E-1:0]   n_inv [m3i_pkg::NUM_ELEM];

    always_comb begin
        logic [E-1:0] q;
        for (int n = 0; n < m3i_pkg::NUM_ELEM; n++) begin
            q = s_q[E][n];
            if (s_sing[E]) begin
                n_inv[n] = '0;
            end else if (s_neg[E][n]) begin
                n_inv[n] = (s_ovf[E][n] || q > MINV) ? MINV : E'(~q + 1'b1);
            end else begin
                n_inv[n] = (s_ovf[E][n] || q[E-1]) ? MAXV : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_valid[E];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sing <= s_sing[E];
        r_detv <= s_detv[E];
        r_inv  <= n_inv;
    end

    assign o_valid     = r_valid;
    assign o_inv       = r_inv;
    assign o_det_value = r_detv;
    assign o_singular  = r_sing;

endmodule

@@ rtl/core/m3i_checker.sv @@
// Port-level assertions for the matrix inverter, bound to the top level.
module m3i_checker #(
    parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [ELEM_WIDTH-1:0] o_inv_r1c1,
    input logic [ELEM_WIDTH-1:0] o_inv_r1c2,
    input logic [ELEM_WIDTH-1:0] o_inv_r1c3,
    input logic [ELEM_WIDTH-1:0] o_inv_r2c1,
    input logic [ELEM_WIDTH-1:0] o_inv_r2c2,
    input logic [ELEM_WIDTH-1:0] o_inv_r2c3,
    input logic [ELEM_WIDTH-1:0] o_inv_r3c1,
    input logic [ELEM_WIDTH-1:0] o_inv_r3c2,
    input logic [ELEM_WIDTH-1:0] o_inv_r3c3,
    input logic [ELEM_WIDTH-1:0] o_det_value,
    input logic                  o_singular
);
    localparam int LAT = m3i_pkg::latency(ELEM_WIDTH);

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted word produced no result");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching accepted word");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !busy)
        else $error("busy raised");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |->
            o_det_value == '0 && o_inv_r1c1 == '0 && o_inv_r1c2 == '0 &&
            o_inv_r1c3 == '0 && o_inv_r2c1 == '0 && o_inv_r2c2 == '0 &&
            o_inv_r2c3 == '0 && o_inv_r3c1 == '0 && o_inv_r3c2 == '0 &&
            o_inv_r3c3 == '0)
        else $error("singular result not all zero");

endmodule

bind matrix3_inverse_determinant_top m3i_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_inv_r1c1  (o_inv_r1c1),
    .o_inv_r1c2  (o_inv_r1c2),
    .o_inv_r1c3  (o_inv_r1c3),
    .o_inv_r2c1  (o_inv_r2c1),
    .o_inv_r2c2  (o_inv_r2c2),
    .o_inv_r2c3  (o_inv_r2c3),
    .o_inv_r3c1  (o_inv_r3c1),
    .o_inv_r3c2  (o_inv_r3c2),
    .o_inv_r3c3  (o_inv_r3c3),
    .o_det_value (o_det_value),
    .o_singular  (o_singular)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the pipelined 3x3 matrix inverter.
module tb_top;

    localparam int EW      = m3i_pkg::ELEM_WIDTH_DEF;
    localparam int FB      = m3i_pkg::FRAC_BITS_DEF;
    localparam int LAT     = m3i_pkg::latency(EW);
    localparam int N_RAND  = 1800;
    localparam logic [EW-1:0] MAXV = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] MINV = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] ONE  = 1 << FB;

    // One matrix word and one result word
    typedef logic [EW-1:0] t_elem;
    typedef t_elem t_mat [9];
    typedef struct {
        t_elem inv [9];
        t_elem det;
        logic  sing;
    } t_res;

    // Directed stimulus row; has_exp marks rows with a typed-in result
    typedef struct {
        t_elem el [9];
        logic  has_exp;
        t_res  exp;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_elem in_el [9];
    logic  o_valid;
    t_elem o_inv [9];
    t_elem o_det_value;
    logic  o_singular;

    t_res expected_q [$];
    int   errors;
    int   n_words;
    int   n_results;
    int   n_singular;
    int   n_sat;

    matrix3_inverse_determinant_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_r1c1  (in_el[0]),
        .i_in_r1c2  (in_el[1]),
        .i_in_r1c3  (in_el[2]),
        .i_in_r2c1  (in_el[3]),
        .i_in_r2c2  (in_el[4]),
        .i_in_r2c3  (in_el[5]),
        .i_in_r3c1  (in_el[6]),
        .i_in_r3c2  (in_el[7]),
        .i_in_r3c3  (in_el[8]),
        .o_valid    (o_valid),
        .o_inv_r1c1 (o_inv[0]),
        .o_inv_r1c2 (o_inv[1]),
        .o_inv_r1c3 (o_inv[2]),
        .o_inv_r2c1 (o_inv[3]),
        .o_inv_r2c2 (o_inv[4]),
        .o_inv_r2c3 (o_inv[5]),
        .o_inv_r3c1 (o_inv[6]),
        .o_inv_r3c2 (o_inv[7]),
        .o_inv_r3c3 (o_inv[8]),
        .o_det_value(o_det_value),
        .o_singular (o_singular)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp a wide signed value into the element range.
    function automatic t_elem clamp(input logic signed [255:0] v);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = $signed({1'b0, MAXV});
        lo = -hi - 1;
        if (v > hi) return MAXV;
        if (v < lo) return MINV;
        return v[EW-1:0];
    endfunction

    // Adjugate / exact determinant / truncating divide, all in 256-bit signed math.
    // SV signed division truncates toward zero, which is what the block does.
    function automatic t_res invert(input t_mat a);
        logic signed [255:0] m [3][3];
        logic signed [255:0] adj [3][3];
        logic signed [255:0] det;
        logic signed [255:0] p;
        logic signed [255:0] q;
        t_res r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = $signed(a[i*3+j]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                p = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3];
                q = m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
                adj[i][j] = p - q;
            end
        det = 0;
        for (int i = 0; i < 3; i++)
            det = det + m[0][i] * adj[i][0];
        r.sing = (det == 0);
        if (r.sing) begin
            foreach (r.inv[k]) r.inv[k] = '0;
            r.det = '0;
            return r;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r.inv[i*3+j] = clamp((adj[i][j] <<< (2*FB)) / det);
        r.det = clamp(det / (256'sd1 <<< (2*FB)));
        return r;
    endfunction

    // Drive one word and hold start until it is taken; start stays high
    // into the next word when no idle cycles are drawn.
    task automatic send_word(input t_mat a, input logic has_exp, input t_res fixed);
        t_res pred;
        int   gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pred = invert(a);
        for (int k = 0; k < 9; k++) in_el[k] = a[k];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(has_exp ? fixed : pred);
        n_words++;
        if (pred.sing) n_singular++;
        if (pred.det == MAXV || pred.det == MINV) n_sat++;
        @(negedge i_clk);
    endtask

    // Result checker: every strobe is compared against the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word", $time);
                errors++;
            end else begin
                e = expected_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (o_inv[k] !== e.inv[k]) begin
                        $display("%0t: inv[%0d] exp %h got %h", $time, k, e.inv[k], o_inv[k]);
                        errors++;
                    end
                if (o_det_value !== e.det) begin
                    $display("%0t: det exp %h got %h", $time, e.det, o_det_value);
                    errors++;
                end
                if (o_singular !== e.sing) begin
                    $display("%0t: singular exp %b got %b", $time, e.sing, o_singular);
                    errors++;
                end
            end
        end
    end

    // Random element: mostly moderate Q16.16 values, some full-range and edge values.
    function automatic t_elem rnd_elem();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return MAXV;
            2:       return MINV;
            3:       return '0;
            4, 5:    return t_elem'($signed($urandom_range(0, 8)) - 4) <<< FB;
            default: return t_elem'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    initial begin
        t_row rows [$];
        t_row r;
        t_mat a;
        t_res z;
        t_res idn;
        int   kind;
        errors = 0; n_words = 0; n_results = 0; n_singular = 0; n_sat = 0;
        start = 1'b0;
        i_rst_n = 1'b0;
        foreach (in_el[k]) in_el[k] = '0;

        // Known answers: zero matrix (singular), identity, its negation
        foreach (z.inv[k]) z.inv[k] = '0;
        z.det = '0; z.sing = 1'b1;
        idn = z; idn.sing = 1'b0; idn.det = ONE;
        idn.inv[0] = ONE; idn.inv[4] = ONE; idn.inv[8] = ONE;

        r.has_exp = 1'b1;
        foreach (r.el[k]) r.el[k] = '0;
        r.exp = z; rows.push_back(r);
        r.el[0] = ONE; r.el[4] = ONE; r.el[8] = ONE;
        r.exp = idn; rows.push_back(r);
        r.el[0] = -ONE; r.el[4] = -ONE; r.el[8] = -ONE;
        r.exp = idn; r.exp.det = -ONE;
        foreach (r.exp.inv[k]) r.exp.inv[k] = -idn.inv[k];
        rows.push_back(r);
        // All-max and all-min: rank one, so singular
        foreach (r.el[k]) r.el[k] = MAXV;
        r.exp = z; rows.push_back(r);
        foreach (r.el[k]) r.el[k] = MINV;
        rows.push_back(r);

        // Predictor-checked rows: extremes on diagonals, tiny values, alternating bits
        r.has_exp = 1'b0;
        foreach (r.el[k]) r.el[k] = '0;
        r.el[0] = MAXV; r.el[4] = MAXV; r.el[8] = MAXV; rows.push_back(r);
        r.el[0] = MINV; r.el[4] = MINV; r.el[8] = MINV; rows.push_back(r);
        r.el[0] = 1; r.el[4] = 1; r.el[8] = 1; rows.push_back(r);
        r.el[0] = -1; r.el[4] = 1; r.el[8] = MAXV; rows.push_back(r);
        r.el[0] = MINV; r.el[4] = MAXV; r.el[8] = 1; rows.push_back(r);
        foreach (r.el[k]) r.el[k] = (k % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
        r.el[4] = ONE; rows.push_back(r);
        foreach (r.el[k]) r.el[k] = (k % 4 == 0) ? ONE * 2 : ((k % 2) ? 32'h8000_0001 : 1);
        rows.push_back(r);
        foreach (r.el[k]) r.el[k] = (k % 4 == 0) ? MAXV : MINV; rows.push_back(r);
        foreach (r.el[k]) r.el[k] = '0;
        r.el[2] = ONE; r.el[4] = ONE; r.el[6] = ONE; rows.push_back(r); // anti-diagonal
        r.el[2] = MAXV; r.el[4] = MINV; r.el[6] = 3; rows.push_back(r);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[n]) begin
            a = rows[n].el;
            send_word(a, rows[n].has_exp, rows[n].exp);
        end

        for (int n = 0; n < N_RAND; n++) begin
            kind = $urandom_range(0, 9);
            foreach (a[k]) a[k] = rnd_elem();
            if (kind == 0) begin
                // duplicate row or column: exactly singular
                for (int c = 0; c < 3; c++) a[3 + c] = a[c];
            end else if (kind == 1) begin
                for (int c = 0; c < 3; c++) a[c*3+2] = a[c*3];
            end else if (kind == 2) begin
                // well-conditioned near-diagonal Q16.16 matrix
                foreach (a[k]) a[k] = t_elem'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
                a[0] = a[0] + ONE; a[4] = a[4] - ONE; a[8] = a[8] + 2 * ONE;
            end else if (kind == 3) begin
                foreach (a[k]) a[k] = $urandom();
            end
            z.sing = 1'b0;
            send_word(a, 1'b0, z);
        end
        start <= 1'b0;

        fork : drain
            wait (expected_q.size() == 0);
            begin
                repeat (LAT * 4) @(posedge i_clk);
            end
        join_any
        disable drain;
        repeat (LAT + 4) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            errors++;
        end

        $display("Ran %0d matrices, %0d results checked, %0d singular, %0d det saturated",
                 n_words, n_results, n_singular, n_sat);
        if (errors == 0)
            $display("matrix3_inverse_determinant_top: match");
        else
            $display("matrix3_inverse_determinant_top: mismatch");
        $finish;
    end

    // Watchdog: each word waits through its drawn idle gap plus the handshake.
    initial begin
        #(12 * 40 * (N_RAND + 200 + 10 * LAT));
        $display("matrix3_inverse_determinant_top: mismatch");
        $finish;
    end

endmodule
